// ===== design/rbm_pkg.sv =====
// rbm_pkg: types and constants shared by the blend unit modules
// no dependencies; imported by rbm_lane, rbm_merge and rgb_blend_mode_unit
`timescale 1ns / 1ps

package rbm_pkg;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pixel_type;

   // one item as it travels beside the lanes
   typedef struct packed {
      logic [2:0] func;
      logic [1:0] chan;
      pixel_type  first;
      pixel_type  second;
   } item_type;

   // blend modes
   localparam logic [2:0] FUNC_MULTIPLY  = 3'd0;
   localparam logic [2:0] FUNC_SUBTRACT  = 3'd1;
   localparam logic [2:0] FUNC_SCREEN    = 3'd2;
   localparam logic [2:0] FUNC_OVERLAY   = 3'd3;
   localparam logic [2:0] FUNC_ADD_GREEN = 3'd4;
   localparam logic [2:0] FUNC_RED_X4    = 3'd5;
   localparam logic [2:0] FUNC_REPLICATE = 3'd6;
   localparam logic [2:0] FUNC_INSERT    = 3'd7;

   // channel select codes
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;

   localparam chan_type CHAN_MAX     = 8'd255;
   localparam chan_type OVERLAY_KNEE = 8'd127;
   localparam chan_type GREEN_BOOST  = 8'd200;

   // round(p / 255) = floor((p + 127) / 255), exact reciprocal for p + 127 < 2**18
   localparam logic [17:0] ROUND_BIAS  = 18'd127;
   localparam logic [18:0] RECIP_255   = 19'd263173;
   localparam int          RECIP_SHIFT = 26;

endpackage

// ===== design/rgb_blend_mode_unit.sv =====
// rgb_blend_mode_unit: blends one pixel pair per clock in one of eight modes
// uses rbm_pkg, rbm_lane (one per color channel) and rbm_merge
//
// usage:
//   - an item (mode plus first and second pixel) is taken at each rising edge
//     with start high and busy low; busy stays low, so one item per clock
//   - the blended pixel shows on rsp_out_* for one cycle with rsp_strobe high,
//     after the three register stages below, in order
//   - latency is set by three register stages: lane product, lane rounded
//     divide by 255 (reciprocal multiply), and the merge/output register
//   - throughput is one item per cycle; three lanes run blue, green and red
//     side by side and the merge stage applies the whole-pixel modes
//   - the receiver cannot stall: every result must be taken when strobed
//   - csr_* writes channel_select (always ready); write it only while no item
//     is in flight
//   - reset clears the strobe pipeline and sets channel_select to blue
`timescale 1ns / 1ps

module rgb_blend_mode_unit
   import rbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_func,
   input  chan_type   req_first_blue,
   input  chan_type   req_first_green,
   input  chan_type   req_first_red,
   input  chan_type   req_second_blue,
   input  chan_type   req_second_green,
   input  chan_type   req_second_red,
   output logic       rsp_strobe,
   output chan_type   rsp_out_blue,
   output chan_type   rsp_out_green,
   output chan_type   rsp_out_red,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   logic       accept;
   logic [1:0] chan_in, chan_ff;
   logic [2:0] valid_in, valid_ff;
   item_type   item_in, item1_ff, item2_ff;
   pixel_type  lanes;
   pixel_type  pixel;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      chan_in = (csr_valid && csr_ready) ? csr_data : chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= CH_BLUE;
         valid_ff <= '0;
      end else begin
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
   end

   assign valid_in = {valid_ff[1:0], accept};

   always_comb begin
      item_in.func         = req_func;
      item_in.chan         = chan_ff;
      item_in.first.blue   = req_first_blue;
      item_in.first.green  = req_first_green;
      item_in.first.red    = req_first_red;
      item_in.second.blue  = req_second_blue;
      item_in.second.green = req_second_green;
      item_in.second.red   = req_second_red;
   end

   // side pipeline keeps the item aligned with the two lane stages
   always_ff @(posedge clock) begin
      item1_ff <= item_in;
      item2_ff <= item1_ff;
   end

   rbm_lane u_lane_blue (
      .clock  (clock),
      .func   (req_func),
      .a      (req_first_blue),
      .b      (req_second_blue),
      .result (lanes.blue)
   );

   rbm_lane u_lane_green (
      .clock  (clock),
      .func   (req_func),
      .a      (req_first_green),
      .b      (req_second_green),
      .result (lanes.green)
   );

   rbm_lane u_lane_red (
      .clock  (clock),
      .func   (req_func),
      .a      (req_first_red),
      .b      (req_second_red),
      .result (lanes.red)
   );

   rbm_merge u_merge (
      .clock (clock),
      .item  (item2_ff),
      .lanes (lanes),
      .pixel (pixel)
   );

   assign rsp_strobe    = valid_ff[2];
   assign rsp_out_blue  = pixel.blue;
   assign rsp_out_green = pixel.green;
   assign rsp_out_red   = pixel.red;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("item accepted but no result three cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result strobe without a matching item");

   a_add_green: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_ADD_GREEN)) |-> ##3 (rsp_out_green >= GREEN_BOOST))
      else $error("add green result below boost");

   a_red_x4_blue: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_RED_X4)) |-> ##3 (rsp_out_blue == '0))
      else $error("red x4 left blue nonzero");

endmodule

// ===== design/rbm_lane.sv =====
// rbm_lane: one color channel of the multiply, subtract, screen and overlay modes
// two register stages: product, then rounded divide by 255; uses rbm_pkg
`timescale 1ns / 1ps

module rbm_lane
   import rbm_pkg::*;
(
   input  logic       clock,
   input  logic [2:0] func,
   input  chan_type   a,
   input  chan_type   b,
   output chan_type   result
);

   chan_type    inv_a;
   chan_type    inv_b;
   chan_type    op_x;
   chan_type    op_y;
   logic        use_inv;
   logic [15:0] prod16;

   logic [16:0] prod_in, prod_ff;
   logic        inv_in, inv_ff;
   logic        sub_sel_in, sub_sel_ff;
   chan_type    sub_in, sub_ff;

   logic [17:0] biased;
   logic [36:0] scaled;
   chan_type    quot;
   chan_type    result_in, result_ff;

   // stage 1: pick operands and multiply
   always_comb begin
      inv_a   = CHAN_MAX - a;
      inv_b   = CHAN_MAX - b;
      use_inv = (func == FUNC_SCREEN) || ((func == FUNC_OVERLAY) && (a > OVERLAY_KNEE));
      op_x    = use_inv ? inv_a : a;
      op_y    = use_inv ? inv_b : b;
      prod16  = 16'(op_x) * 16'(op_y);
      // overlay works on twice the product
      prod_in    = (func == FUNC_OVERLAY) ? {prod16, 1'b0} : {1'b0, prod16};
      inv_in     = use_inv;
      sub_sel_in = (func == FUNC_SUBTRACT);
      sub_in     = (b > a) ? (b - a) : '0;
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      inv_ff     <= inv_in;
      sub_sel_ff <= sub_sel_in;
      sub_ff     <= sub_in;
   end

   // stage 2: rounded divide by 255 through the reciprocal
   always_comb begin
      biased = {1'b0, prod_ff} + ROUND_BIAS;
      scaled = 37'(biased) * 37'(RECIP_255);
      quot   = scaled[RECIP_SHIFT +: 8];
      if (sub_sel_ff) begin
         result_in = sub_ff;
      end else if (inv_ff) begin
         result_in = CHAN_MAX - quot;
      end else begin
         result_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/rbm_merge.sv =====
// rbm_merge: combines the lane results with the per-pixel modes into the output pixel
// one register stage; uses rbm_pkg
`timescale 1ns / 1ps

module rbm_merge
   import rbm_pkg::*;
(
   input  logic      clock,
   input  item_type  item,
   input  pixel_type lanes,
   output pixel_type pixel
);

   pixel_type pixel_in, pixel_ff;
   logic [8:0] green_sum;
   chan_type   green_sat;
   chan_type   red_sat;
   chan_type   picked;

   always_comb begin
      green_sum = {1'b0, item.first.green} + {1'b0, GREEN_BOOST};
      green_sat = green_sum[8] ? CHAN_MAX : green_sum[7:0];
      red_sat   = (item.first.red[7:6] != 2'b00) ? CHAN_MAX : {item.first.red[5:0], 2'b00};

      case (item.chan)
         CH_BLUE:  picked = item.first.blue;
         CH_GREEN: picked = item.first.green;
         CH_RED:   picked = item.first.red;
         default:  picked = item.first.blue;
      endcase

      pixel_in = item.first;
      case (item.func)
         FUNC_MULTIPLY, FUNC_SUBTRACT, FUNC_SCREEN, FUNC_OVERLAY: begin
            pixel_in = lanes;
         end
         FUNC_ADD_GREEN: begin
            pixel_in.green = green_sat;
         end
         FUNC_RED_X4: begin
            pixel_in.blue = '0;
            pixel_in.red  = red_sat;
         end
         FUNC_REPLICATE: begin
            // unused selector passes the first pixel through
            if (item.chan inside {CH_BLUE, CH_GREEN, CH_RED}) begin
               pixel_in.blue  = picked;
               pixel_in.green = picked;
               pixel_in.red   = picked;
            end
         end
         FUNC_INSERT: begin
            case (item.chan)
               CH_BLUE:  pixel_in.blue  = item.second.blue;
               CH_GREEN: pixel_in.green = item.second.green;
               CH_RED:   pixel_in.red   = item.second.red;
               default:  pixel_in = item.first;
            endcase
         end
         default: begin
            pixel_in = item.first;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

// ===== tb/tb_rgb_blend_mode_unit.sv =====
// tb_rgb_blend_mode_unit: self-checking bench for the pixel blend unit, directed then random
// depends on rbm_pkg and rgb_blend_mode_unit; the scoreboard class predicts every blended pixel
`timescale 1ns / 1ps

module tb_rgb_blend_mode_unit;
   import rbm_pkg::*;

   // selector value that maps to no channel
   localparam logic [1:0] CH_NONE = 2'd3;

   class blend_board;
      pixel_type  expected_q[$];
      logic [1:0] chan_sel;
      int         fail_count;

      function new();
         chan_sel   = CH_BLUE;
         fail_count = 0;
      endfunction

      // value given as twice the numerator, rounded divide by 255
      function chan_type round_div(int unsigned twice_num);
         return chan_type'((twice_num + 255) / 510);
      endfunction

      function chan_type blend_lane(logic [2:0] mode, chan_type a, chan_type b);
         int unsigned av, bv, ia, ib;
         av = a;
         bv = b;
         ia = 255 - av;
         ib = 255 - bv;
         case (mode)
            FUNC_MULTIPLY: return round_div(2 * av * bv);
            FUNC_SUBTRACT: return (bv > av) ? chan_type'(bv - av) : '0;
            FUNC_SCREEN:   return CHAN_MAX - round_div(2 * ia * ib);
            default: begin
               if (av <= OVERLAY_KNEE) return round_div(4 * av * bv);
               return CHAN_MAX - round_div(4 * ia * ib);
            end
         endcase
      endfunction

      function void note(logic [2:0] func, pixel_type first, pixel_type second);
         pixel_type   px;
         int unsigned widened;
         chan_type    pick;
         px = first;
         case (func)
            FUNC_MULTIPLY, FUNC_SUBTRACT, FUNC_SCREEN, FUNC_OVERLAY: begin
               px.blue  = blend_lane(func, first.blue, second.blue);
               px.green = blend_lane(func, first.green, second.green);
               px.red   = blend_lane(func, first.red, second.red);
            end
            FUNC_ADD_GREEN: begin
               widened  = first.green + GREEN_BOOST;
               px.green = (widened > CHAN_MAX) ? CHAN_MAX : chan_type'(widened);
            end
            FUNC_RED_X4: begin
               widened = first.red * 4;
               px.blue = '0;
               px.red  = (widened > CHAN_MAX) ? CHAN_MAX : chan_type'(widened);
            end
            FUNC_REPLICATE: begin
               if (chan_sel != CH_NONE) begin
                  case (chan_sel)
                     CH_BLUE:  pick = first.blue;
                     CH_GREEN: pick = first.green;
                     default:  pick = first.red;
                  endcase
                  px.blue  = pick;
                  px.green = pick;
                  px.red   = pick;
               end
            end
            default: begin
               case (chan_sel)
                  CH_BLUE:  px.blue  = second.blue;
                  CH_GREEN: px.green = second.green;
                  CH_RED:   px.red   = second.red;
                  default:  px = first;
               endcase
            end
         endcase
         expected_q = {expected_q, px};
      endfunction

      function void compare(string field, chan_type want, chan_type got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
         end
      endfunction

      function void check(pixel_type got);
         pixel_type want;
         if (expected_q.size() == 0) begin
            $error("result with no item pending: blue %0d green %0d red %0d",
                   got.blue, got.green, got.red);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         compare("out_blue", want.blue, got.blue);
         compare("out_green", want.green, got.green);
         compare("out_red", want.red, got.red);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_func;
   chan_type   req_first_blue, req_first_green, req_first_red;
   chan_type   req_second_blue, req_second_green, req_second_red;
   logic       rsp_strobe;
   chan_type   rsp_out_blue, rsp_out_green, rsp_out_red;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_data;

   pixel_type  req_first_px, req_second_px, rsp_px;
   blend_board board;
   int         sender_idle_pct;
   logic [1:0] sel_plan [8] = '{CH_GREEN, CH_NONE, CH_RED, CH_BLUE,
                                CH_RED, CH_NONE, CH_GREEN, CH_BLUE};

   assign req_first_px  = {req_first_blue, req_first_green, req_first_red};
   assign req_second_px = {req_second_blue, req_second_green, req_second_red};
   assign rsp_px        = {rsp_out_blue, rsp_out_green, rsp_out_red};

   rgb_blend_mode_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_first_blue   (req_first_blue),
      .req_first_green  (req_first_green),
      .req_first_red    (req_first_red),
      .req_second_blue  (req_second_blue),
      .req_second_green (req_second_green),
      .req_second_red   (req_second_red),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.chan_sel = csr_data;
         if (start && !busy) board.note(req_func, req_first_px, req_second_px);
         if (rsp_strobe) board.check(rsp_px);
      end
   end

   // mostly spread values, with extra weight on the ends and the overlay knee
   function automatic chan_type rand_chan();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0:       return '0;
         1:       return CHAN_MAX;
         2:       return chan_type'($urandom_range(129, 126));
         default: return chan_type'($urandom_range(255));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(logic [2:0] func, chan_type fb, chan_type fg, chan_type fr,
                            chan_type sb, chan_type sg, chan_type sr);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_func         <= func;
      req_first_blue   <= fb;
      req_first_green  <= fg;
      req_first_red    <= fr;
      req_second_blue  <= sb;
      req_second_green <= sg;
      req_second_red   <= sr;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      send_item(3'($urandom_range(7)), rand_chan(), rand_chan(), rand_chan(),
                rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic write_chan_sel(logic [1:0] sel);
      csr_valid <= 1'b1;
      csr_data  <= sel;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (board.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      board            = new();
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_MULTIPLY;
      req_first_blue   = '0;
      req_first_green  = '0;
      req_first_red    = '0;
      req_second_blue  = '0;
      req_second_green = '0;
      req_second_red   = '0;
      csr_valid        = 1'b0;
      csr_data         = CH_BLUE;
      sender_idle_pct  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items with the selector at its reset value
      send_item(FUNC_MULTIPLY, 0, 0, 0, 0, 0, 0);
      send_item(FUNC_MULTIPLY, 255, 255, 255, 255, 255, 255);
      send_item(FUNC_MULTIPLY, 255, 0, 128, 0, 255, 128);
      send_item(FUNC_SUBTRACT, 0, 255, 100, 255, 0, 100);
      send_item(FUNC_SUBTRACT, 255, 255, 255, 0, 0, 0);
      send_item(FUNC_SCREEN, 0, 255, 0, 0, 0, 255);
      send_item(FUNC_SCREEN, 255, 255, 127, 255, 255, 128);
      // overlay on both sides of the knee
      send_item(FUNC_OVERLAY, 127, 128, 0, 255, 255, 255);
      send_item(FUNC_OVERLAY, 127, 128, 255, 0, 0, 0);
      send_item(FUNC_OVERLAY, 255, 0, 128, 255, 255, 1);
      // add green just below, at and above saturation
      send_item(FUNC_ADD_GREEN, 7, 55, 9, 255, 255, 255);
      send_item(FUNC_ADD_GREEN, 200, 56, 1, 0, 0, 0);
      send_item(FUNC_ADD_GREEN, 255, 0, 255, 0, 0, 0);
      send_item(FUNC_ADD_GREEN, 0, 255, 0, 0, 0, 0);
      // red x4 around the saturation point
      send_item(FUNC_RED_X4, 255, 77, 63, 1, 2, 3);
      send_item(FUNC_RED_X4, 1, 0, 64, 0, 0, 0);
      send_item(FUNC_RED_X4, 255, 255, 255, 255, 255, 255);
      send_item(FUNC_RED_X4, 0, 0, 0, 0, 0, 0);
      send_item(FUNC_REPLICATE, 17, 34, 51, 200, 201, 202);
      send_item(FUNC_REPLICATE, 255, 0, 0, 0, 0, 0);
      send_item(FUNC_INSERT, 10, 20, 30, 240, 250, 255);
      send_item(FUNC_INSERT, 255, 255, 255, 0, 0, 0);
      wait_idle();

      // random phases, each setting the selector from its plan and the sender pacing
      for (int phase = 0; phase < 8; phase++) begin
         sender_idle_pct = (phase < 3) ? 30 : (phase < 6) ? 74 : 0;
         write_chan_sel(sel_plan[phase]);
         repeat (50) send_random_item();
         wait_idle();
      end

      repeat (6) @(negedge clock);
      if (board.fail_count == 0 && board.expected_q.size() == 0) begin
         $display("tb_rgb_blend_mode_unit: clean");
      end else begin
         $display("tb_rgb_blend_mode_unit: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_rgb_blend_mode_unit: errors");
      $finish;
   end

endmodule
